// ----- src/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

    localparam int BYTE_W      = 8;
    localparam int SIG_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LIMIT_RESET = 50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 3'd0,
        CFG_PAT_HIGH = 3'd1,
        CFG_CARE     = 3'd2,
        CFG_LENGTH   = 3'd3,
        CFG_LIMIT    = 3'd4
    } cfg_reg_t;

    // Signature settings as seen by the compare logic; length is already capped.
    typedef struct packed {
        logic [SIG_BYTES*BYTE_W-1:0] pattern;
        logic [SIG_BYTES-1:0]        care;
        logic [LEN_W-1:0]            length;
    } sig_cfg_t;

endpackage

`default_nettype wire

// ----- src/wildcard_byte_pattern_scanner.sv -----
// Top level of the wildcard byte pattern scanner: stream ports, state and result register.
`default_nettype none

// The scanner takes one byte per clock on the s_ side and returns one result
// transaction per byte on the m_ side, through an input register and then a
// result register. Throughput is one byte per cycle while the output is not
// stalled, set by the combinational window compare between the two registers;
// the input register lets one more byte in while a result waits. Each result
// says whether a signature match ends at that byte, the address of the first
// byte of that match, the matches reported in the current scan and whether the
// match limit has been reached. Configuration is written through cfg_wen/
// cfg_index/cfg_wdata while the stream is idle; the user, not the block, ensures it.

module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX  = 16,
    parameter int ADDRESS_BITS = 47
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: data_byte, byte_address, zero fill
    input  logic [((BYTE_W+ADDRESS_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: region_start, new_scan
    input  logic [1:0]            s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: match_found, match_address, matches_so_far, limit_reached, zero fill
    output logic [((2+ADDRESS_BITS+CNT_W+7)/8)*8-1:0] m_tdata
);

    localparam int CMP_N    = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;
    localparam int WIN_N    = PATTERN_MAX - 1;
    localparam int BIR_W    = $clog2(PATTERN_MAX);

    // Configuration registers.
    logic [CFG_W-1:0]     pat_low_reg;
    logic [CFG_W-1:0]     pat_high_reg;
    logic [SIG_BYTES-1:0] care_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [CNT_W-1:0]     limit_reg;

    // Input stage.
    logic                    a_valid_reg;
    logic [BYTE_W-1:0]       a_byte_reg;
    logic [ADDRESS_BITS-1:0] a_addr_reg;
    logic                    a_rstart_reg;
    logic                    a_nscan_reg;

    // Scan state.
    logic [BYTE_W-1:0] win_reg  [WIN_N];
    logic [BYTE_W-1:0] win_eff  [WIN_N];
    logic [BYTE_W-1:0] win_next [WIN_N];
    logic [BIR_W-1:0]  bir_reg;
    logic [BIR_W-1:0]  bir_eff;
    logic [BIR_W-1:0]  bir_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_next;

    // Result stage.
    logic                    o_valid_reg;
    logic                    o_found_reg;
    logic [ADDRESS_BITS-1:0] o_addr_reg;
    logic [CNT_W-1:0]        o_cnt_reg;
    logic                    o_limit_reg;

    logic                    advance;
    logic [LEN_W-1:0]        len_eff;
    sig_cfg_t                sig_cfg;
    logic [BYTE_W-1:0]       seq [CMP_N];
    logic                    fit;
    logic                    enough_bytes;
    logic                    report;
    logic [ADDRESS_BITS-1:0] start_addr;

    assign advance  = a_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || !o_valid_reg || m_tready;

    assign len_eff = (len_reg > LEN_W'(CMP_N)) ? LEN_W'(CMP_N) : len_reg;

    assign sig_cfg.pattern = {pat_high_reg, pat_low_reg};
    assign sig_cfg.care    = care_reg;
    assign sig_cfg.length  = len_eff;

    // A region start empties the window before this byte is looked at.
    always_comb
    begin
        for (int k = 0; k < WIN_N; k++)
        begin
            win_eff[k] = a_rstart_reg ? '0 : win_reg[k];
        end
        bir_eff = a_rstart_reg ? '0 : bir_reg;

        seq[0] = a_byte_reg;
        for (int j = 1; j < CMP_N; j++)
        begin
            seq[j] = win_eff[j-1];
        end

        win_next[0] = a_byte_reg;
        for (int k = 1; k < WIN_N; k++)
        begin
            win_next[k] = win_eff[k-1];
        end
        bir_next = (bir_eff < BIR_W'(WIN_N)) ? bir_eff + BIR_W'(1) : bir_eff;
    end

    wbps_sig_cmp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_sig_cmp (
        .cfg (sig_cfg),
        .seq (seq),
        .fit (fit)
    );

    always_comb
    begin
        enough_bytes = (int'(bir_eff) + 1) >= int'(len_eff);
        cnt_eff      = a_nscan_reg ? '0 : cnt_reg;
        report       = fit && enough_bytes && (cnt_eff < limit_reg);
        cnt_next     = (report && (cnt_eff != '1)) ? cnt_eff + CNT_W'(1) : cnt_eff;
        start_addr   = report ? (a_addr_reg - ADDRESS_BITS'(len_eff) + ADDRESS_BITS'(1))
                              : '0;
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '1;
            len_reg      <= LEN_W'(1);
            limit_reg    <= CNT_W'(LIMIT_RESET);
            a_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            bir_reg      <= '0;
            cnt_reg      <= '0;
            for (int k = 0; k < WIN_N; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                    CFG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                    CFG_CARE:     care_reg     <= cfg_wdata[SIG_BYTES-1:0];
                    CFG_LENGTH:   len_reg      <= cfg_wdata[LEN_W-1:0];
                    CFG_LIMIT:    limit_reg    <= cfg_wdata[CNT_W-1:0];
                    default:      ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                o_valid_reg <= 1'b1;
                bir_reg     <= bir_next;
                cnt_reg     <= cnt_next;
                win_reg     <= win_next;
            end
            else if (m_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_byte_reg   <= s_tdata[BYTE_W-1:0];
            a_addr_reg   <= s_tdata[BYTE_W +: ADDRESS_BITS];
            a_rstart_reg <= s_tuser[0];
            a_nscan_reg  <= s_tuser[1];
        end
        if (advance)
        begin
            o_found_reg <= report;
            o_addr_reg  <= start_addr;
            o_cnt_reg   <= cnt_next;
            o_limit_reg <= (cnt_next >= limit_reg);
        end
    end

    assign m_tvalid = o_valid_reg;

    always_comb
    begin
        m_tdata                            = '0;
        m_tdata[0]                         = o_found_reg;
        m_tdata[ADDRESS_BITS:1]            = o_addr_reg;
        m_tdata[ADDRESS_BITS+1 +: CNT_W]   = o_cnt_reg;
        m_tdata[ADDRESS_BITS+1+CNT_W]      = o_limit_reg;
    end

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !m_tready |-> !advance)
        else $error("result register overwritten while stalled");

    a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_found_reg |-> o_cnt_reg != '0)
        else $error("reported match with zero match count");

    a_no_match_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_found_reg |-> o_addr_reg == '0)
        else $error("match address set without a match");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(bir_reg) <= WIN_N)
        else $error("window fill count beyond window depth");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> a_valid_reg && o_valid_reg)
        else $error("input refused while a stage is free");

endmodule

`default_nettype wire

// ----- src/wbps_sig_cmp.sv -----
// Parallel wildcard compare of the newest bytes of a region against the signature.
`default_nettype none

module wbps_sig_cmp
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  sig_cfg_t             cfg,
    // seq[0] is the newest byte, seq[k] the byte k positions earlier.
    input  logic [BYTE_W-1:0]    seq [(PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES],
    output logic                 fit
);

    localparam int CMP_N = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;

    logic [CMP_N-1:0] ok;

    // Pattern byte i lines up with the byte (length - 1 - i) positions back.
    always_comb
    begin
        for (int i = 0; i < CMP_N; i++)
        begin
            ok[i] = 1'b1;
            if ((LEN_W'(i) < cfg.length) && cfg.care[i])
            begin
                for (int j = 0; j < CMP_N; j++)
                begin
                    if (LEN_W'(i + j + 1) == cfg.length)
                    begin
                        ok[i] = (seq[j] == cfg.pattern[BYTE_W*i +: BYTE_W]);
                    end
                end
            end
        end
        fit = (cfg.length != '0) && (&ok);
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the wildcard byte pattern scanner.
`timescale 1ns / 100ps

module tb
    import wbps_pkg::*;
();

    localparam int ADDR_W      = 47;
    localparam int S_W         = ((BYTE_W + ADDR_W + 7) / 8) * 8;
    localparam int M_W         = ((2 + ADDR_W + CNT_W + 7) / 8) * 8;
    localparam int WIN_DEPTH   = SIG_BYTES - 1;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct {
        bit                found;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        bit                at_limit;
    } scan_report_t;

    // Tracks the scanner state and holds the reports still owed by the block.
    class scan_checker;
        logic [CFG_W-1:0]     sig_low;
        logic [CFG_W-1:0]     sig_high;
        logic [SIG_BYTES-1:0] care;
        logic [LEN_W-1:0]     length_reg;
        logic [CNT_W-1:0]     limit;
        logic [7:0]           window [WIN_DEPTH];
        int unsigned          region_fill;
        logic [CNT_W-1:0]     match_count;
        scan_report_t         pending_reports [$];
        int unsigned          mismatches;

        function new();
            sig_low     = '0;
            sig_high    = '0;
            care        = '1;
            length_reg  = 1;
            limit       = LIMIT_RESET;
            region_fill = 0;
            match_count = '0;
            mismatches  = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PAT_LOW:  sig_low = val;
                CFG_PAT_HIGH: sig_high = val;
                CFG_CARE:     care = val[SIG_BYTES-1:0];
                CFG_LENGTH:   length_reg = val[LEN_W-1:0];
                CFG_LIMIT:    limit = val[CNT_W-1:0];
                default:      ;
            endcase
        endfunction

        function int unsigned active_length();
            return (int'(length_reg) > SIG_BYTES) ? SIG_BYTES : int'(length_reg);
        endfunction

        function logic [7:0] sig_byte(int unsigned i);
            logic [2*CFG_W-1:0] sig;
            sig = {sig_high, sig_low};
            return sig[8*i +: 8];
        endfunction

        function int unsigned pending();
            return pending_reports.size();
        endfunction

        // Works out the report for one accepted byte and updates the window.
        function void note_byte(logic [7:0] data, logic [ADDR_W-1:0] addr, bit rs, bit ns);
            int unsigned  len;
            bit           hit;
            logic [7:0]   b;
            scan_report_t r;
            len = active_length();
            if (ns)
                match_count = '0;
            if (rs)
            begin
                foreach (window[i]) window[i] = '0;
                region_fill = 0;
            end
            hit = 0;
            if (len >= 1 && region_fill + 1 >= len)
            begin
                hit = 1;
                for (int i = 0; i < len; i++)
                begin
                    if (care[i])
                    begin
                        b = (i == len - 1) ? data : window[len - 2 - i];
                        if (b != sig_byte(i))
                            hit = 0;
                    end
                end
            end
            r.found = 0;
            r.addr  = '0;
            if (hit && match_count < limit)
            begin
                r.found = 1;
                r.addr  = addr - ADDR_W'(len - 1);
                match_count++;
            end
            for (int i = WIN_DEPTH - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = data;
            if (region_fill < WIN_DEPTH)
                region_fill++;
            r.count    = match_count;
            r.at_limit = (match_count >= limit);
            pending_reports.insert(pending_reports.size(), r);
        endfunction

        function void check_result(logic [M_W-1:0] d);
            scan_report_t e;
            scan_report_t a;
            a.found    = d[0];
            a.addr     = d[ADDR_W:1];
            a.count    = d[ADDR_W+CNT_W:ADDR_W+1];
            a.at_limit = d[ADDR_W+CNT_W+1];
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result found=%0b addr=%h count=%0d limit=%0b",
                             a.found, a.addr, a.count, a.at_limit);
                return;
            end
            e = pending_reports.pop_front();
            if (a.found != e.found || a.addr != e.addr || a.count != e.count
                || a.at_limit != e.at_limit)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: expected found=%0b addr=%h count=%0d limit=%0b",
                             e.found, e.addr, e.count, e.at_limit);
                    $display("       got      found=%0b addr=%h count=%0d limit=%0b",
                             a.found, a.addr, a.count, a.at_limit);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PAT_LOW;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_W-1:0]       m_tdata;

    scan_checker          sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          hold_seq = 0;
    int unsigned          hold_seen = 0;
    int unsigned          hold_left = 0;
    int unsigned          cycle_count = 0;
    int unsigned          items_sent = 0;
    logic [ADDR_W-1:0]    next_addr = '0;

    wildcard_byte_pattern_scanner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off whenever hold_seq moves.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic send_item(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
                             input bit rs, input bit ns);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, addr, data};
        s_tuser  <= {ns, rs};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(data, addr, rs, ns);
    endtask

    task automatic emit(input logic [7:0] data, input bit rs, input bit ns);
        send_item(data, next_addr, rs, ns);
        next_addr  = next_addr + 1;
        items_sent = items_sent + 1;
    endtask

    // Stops offering bytes until every report has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic [7:0] limit);
        drain();
        write_reg(CFG_PAT_LOW, lo);
        write_reg(CFG_PAT_HIGH, hi);
        write_reg(CFG_CARE, CFG_W'(care));
        write_reg(CFG_LENGTH, CFG_W'(len));
        write_reg(CFG_LIMIT, CFG_W'(limit));
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic jump_address();
        case ($urandom_range(3))
            0:       next_addr = ADDR_MAX - ADDR_W'($urandom_range(20));
            1:       next_addr = ADDR_W'($urandom_range(5));
            default: next_addr = ADDR_W'({$urandom, $urandom});
        endcase
    endtask

    // Mostly whole signatures with random wildcard content, some spoiled ones,
    // region jumps, scan restarts and plain noise.
    task automatic run_random(input int unsigned n);
        int unsigned target;
        int unsigned kind;
        int unsigned len;
        int unsigned spoil;
        int unsigned pos;
        logic [7:0]  b;
        target = items_sent + n;
        while (items_sent < target)
        begin
            kind = $urandom_range(99);
            len  = sb.active_length();
            if (kind < 60 && len != 0)
            begin
                spoil = $urandom_range(9);
                pos   = $urandom_range(len - 1);
                for (int i = 0; i < len; i++)
                begin
                    b = sb.care[i] ? sb.sig_byte(i) : 8'($urandom);
                    if (spoil == 0 && i == pos)
                        b = ~b;
                    emit(b, spoil == 1 && i == pos, 1'b0);
                end
            end
            else if (kind < 72)
            begin
                jump_address();
                emit(8'($urandom), 1'b1, $urandom_range(3) == 0);
            end
            else if (kind < 78)
            begin
                emit(8'($urandom), 1'b0, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    emit(8'($urandom), $urandom_range(49) == 0, 1'b0);
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [15:0]      care;
        logic [4:0]       len;
        logic [7:0]       limit;
        int unsigned      pick;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-byte signature of zero, limit 50.
        next_addr = '0;
        emit(8'h00, 1'b1, 1'b1);
        next_addr = ADDR_MAX - 1;
        emit(8'hFF, 1'b1, 1'b0);
        emit(8'h00, 1'b0, 1'b0);

        // Four-byte signature with a wildcard in byte 2, limit of two.
        set_config(64'h0000_0000_C3A5_5A3C, 64'h0, 16'hFFFB, 5'd4, 8'd2);
        next_addr = '0;
        emit(8'h3C, 1'b1, 1'b1);
        emit(8'h5A, 1'b0, 1'b0);
        emit(8'h77, 1'b0, 1'b0);
        emit(8'hC3, 1'b0, 1'b0);
        // Match whose first byte lies below address zero once wrapped.
        next_addr = ADDR_MAX - 1;
        emit(8'h3C, 1'b1, 1'b0);
        emit(8'h5A, 1'b0, 1'b0);
        emit(8'h00, 1'b0, 1'b0);
        emit(8'hC3, 1'b0, 1'b0);
        // Scan restart on the last byte keeps the window, so this still matches.
        emit(8'h3C, 1'b0, 1'b0);
        emit(8'h5A, 1'b0, 1'b0);
        emit(8'h11, 1'b0, 1'b0);
        emit(8'hC3, 1'b0, 1'b1);

        // Zero length never matches; zero limit counts as reached.
        set_config(64'h0, 64'h0, 16'hFFFF, 5'd0, 8'd0);
        emit(8'h3C, 1'b1, 1'b1);
        emit(8'h00, 1'b0, 1'b0);

        // Limit raised in the middle of a scan lets reporting resume.
        set_config(64'h5A, 64'h0, 16'hFFFF, 5'd1, 8'd0);
        emit(8'h5A, 1'b0, 1'b0);
        set_config(64'h5A, 64'h0, 16'hFFFF, 5'd1, 8'd1);
        emit(8'h5A, 1'b0, 1'b0);

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 4)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 75;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: set_config('1, '0, 16'hFFFF, 5'd16, 8'd255);
                1: set_config({$urandom, $urandom}, '1, 16'h0000, 5'd31, 8'd1);
                2: set_config('0, '0, 16'hFFFF, 5'd1, 8'd3);
                default:
                begin
                    lo   = {$urandom, $urandom};
                    hi   = {$urandom, $urandom};
                    care = 16'($urandom | $urandom);
                    len  = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 8));
                    pick = $urandom_range(99);
                    if (pick < 10)
                        limit = 8'd0;
                    else if (pick < 20)
                        limit = 8'd255;
                    else
                        limit = 8'($urandom_range(1, 10));
                    set_config(lo, hi, care, len, limit);
                end
            endcase
            // Long output stall while bytes keep coming, so the input backs up.
            if (phase == 8 || phase == 10)
                hold_seq <= hold_seq + 1;
            run_random(75);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- wildcard_byte_pattern_scanner.f -----
src/wbps_pkg.sv
src/wbps_sig_cmp.sv
src/wildcard_byte_pattern_scanner.sv
tb/tb.sv
